>>> src/pia_ports_with_rom_mapping_macros.svh
// Assertion macros for the PIA block.
// Expects i_clk and i_rst_n in the scope of each use.
`ifndef PIA_PORTS_WITH_ROM_MAPPING_MACROS_SVH
`define PIA_PORTS_WITH_ROM_MAPPING_MACROS_SVH

// Checked at every rising edge outside reset.
`define PIA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define PIA_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> src/pia_pkg.sv
// Package for the PIA block: field widths, register selects, bit masks.
// No dependencies.
`timescale 1ns / 1ps

package pia_pkg;

    localparam int unsigned DATA_W = 8;
    localparam int unsigned SEL_W  = 2;
    localparam int unsigned CTL_W  = 6;
    localparam int unsigned MAP_W  = 3;

    // register selects
    localparam logic [SEL_W-1:0] SEL_PORT_A = 2'd0;
    localparam logic [SEL_W-1:0] SEL_PORT_B = 2'd1;
    localparam logic [SEL_W-1:0] SEL_CTRL_A = 2'd2;
    localparam logic [SEL_W-1:0] SEL_CTRL_B = 2'd3;

    // access kind
    localparam logic MODE_READ  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    // control register bit that routes the port address to the data side
    localparam int unsigned CTL_DATA_BIT = 2;

    localparam logic [DATA_W-1:0] PB_KEEP_MASK  = 8'h83;
    localparam logic [DATA_W-1:0] PB_FORCE_ONES = 8'h7c;
    localparam logic [DATA_W-1:0] PB_RESET      = 8'hff;

    // port B bits that drive the memory map
    localparam int unsigned PB_OS_BIT    = 0;
    localparam int unsigned PB_BASIC_BIT = 1;
    localparam int unsigned PB_TEST_BIT  = 7;

    // map_changed bit positions
    localparam int unsigned MAP_OS    = 0;
    localparam int unsigned MAP_BASIC = 1;
    localparam int unsigned MAP_TEST  = 2;

endpackage

>>> src/pia_ifs.sv
// Valid/ready channel interfaces for bus accesses and their results.
// Depends on pia_pkg.
`timescale 1ns / 1ps

interface pia_req_if
    import pia_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              mode;
    logic [SEL_W-1:0]  reg_sel;
    logic [DATA_W-1:0] write_data;
    logic [DATA_W-1:0] joystick_in;

    modport source (output valid, mode, reg_sel, write_data, joystick_in, input ready);
    modport sink   (input valid, mode, reg_sel, write_data, joystick_in, output ready);
endinterface

interface pia_rsp_if
    import pia_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] read_data;
    logic              os_rom_on;
    logic              basic_rom_on;
    logic              selftest_rom_on;
    logic [MAP_W-1:0]  map_changed;

    modport source (output valid, read_data, os_rom_on, basic_rom_on, selftest_rom_on,
                    map_changed, input ready);
    modport sink   (input valid, read_data, os_rom_on, basic_rom_on, selftest_rom_on,
                    map_changed, output ready);
endinterface

>>> src/pia_ports_with_rom_mapping.sv
// Two-port parallel interface with port B driven memory-map enables.
// Depends on pia_pkg, pia_ifs.sv and pia_ports_with_rom_mapping_macros.svh.
//
//  channel  | dir | transfer                      | payload
//  ---------+-----+-------------------------------+----------------------------------------
//  i_req    | in  | one bus access                | mode, reg_sel, write_data, joystick_in
//  o_rsp    | out | one result per access         | read_data, rom enables, map_changed
//
// One access per cycle while i_req.ready is high; each result appears in the cycle after its transfer.
// The only storage in the path is the result register; the register file
// update and the readback are a single level of muxing behind it.
// i_req.ready falls only while a result waits and o_rsp.ready is low, so a
// waiting result never blocks the next access once it is taken.
// Synchronous active-low reset: ports and control cleared, port B = 0xff
// (OS ROM in, BASIC and self-test out), result register empty.
`timescale 1ns / 1ps
`include "pia_ports_with_rom_mapping_macros.svh"

module pia_ports_with_rom_mapping
    import pia_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    pia_req_if.sink   i_req,
    pia_rsp_if.source o_rsp
);

    // architectural state
    logic [DATA_W-1:0] r_out_reg_a, n_out_reg_a;
    logic [DATA_W-1:0] r_dir_reg_a, n_dir_reg_a;
    logic [DATA_W-1:0] r_dir_reg_b, n_dir_reg_b;
    logic [DATA_W-1:0] r_port_b,    n_port_b;
    logic [CTL_W-1:0]  r_ctrl_a,    n_ctrl_a;
    logic [CTL_W-1:0]  r_ctrl_b,    n_ctrl_b;

    // result register
    logic              r_out_valid;
    logic [DATA_W-1:0] r_read_data, n_read_data;
    logic [MAP_W-1:0]  r_map_chg,   n_map_chg;
    logic              r_os_on, r_basic_on, r_test_on;

    logic              accept;
    logic              is_write;
    logic              pb_data_wr;
    logic [DATA_W-1:0] pb_diff;

    // result slot is free when empty or being drained this cycle
    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign accept      = i_req.valid && i_req.ready;
    assign is_write    = (i_req.mode == MODE_WRITE);
    assign pb_diff     = r_port_b ^ i_req.write_data;
    // port B data write: the only access that can switch the map
    assign pb_data_wr  = is_write && (i_req.reg_sel == SEL_PORT_B) && r_ctrl_b[CTL_DATA_BIT];

    always_comb begin
        n_out_reg_a = r_out_reg_a;
        n_dir_reg_a = r_dir_reg_a;
        n_dir_reg_b = r_dir_reg_b;
        n_port_b    = r_port_b;
        n_ctrl_a    = r_ctrl_a;
        n_ctrl_b    = r_ctrl_b;
        n_map_chg   = '0;
        n_read_data = '0;

        unique case (i_req.reg_sel)
            SEL_PORT_A: begin
                if (!r_ctrl_a[CTL_DATA_BIT]) begin
                    if (is_write) n_dir_reg_a = i_req.write_data;
                    n_read_data = n_dir_reg_a;
                end else begin
                    if (is_write) n_out_reg_a = i_req.write_data;
                    // input pins pulled by output latch where driven
                    n_read_data = i_req.joystick_in & (n_out_reg_a | ~r_dir_reg_a);
                end
            end
            SEL_PORT_B: begin
                if (!r_ctrl_b[CTL_DATA_BIT]) begin
                    if (is_write) n_dir_reg_b = i_req.write_data;
                    n_read_data = n_dir_reg_b;
                end else begin
                    if (is_write) begin
                        n_map_chg[MAP_OS]    = pb_diff[PB_OS_BIT];
                        n_map_chg[MAP_BASIC] = pb_diff[PB_BASIC_BIT];
                        n_map_chg[MAP_TEST]  = pb_diff[PB_TEST_BIT];
                        n_port_b = (i_req.write_data & PB_KEEP_MASK) | PB_FORCE_ONES;
                    end
                    // direction register not applied on port B reads
                    n_read_data = n_port_b;
                end
            end
            SEL_CTRL_A: begin
                if (is_write) n_ctrl_a = i_req.write_data[CTL_W-1:0];
                n_read_data = {{(DATA_W-CTL_W){1'b0}}, n_ctrl_a};
            end
            SEL_CTRL_B: begin
                if (is_write) n_ctrl_b = i_req.write_data[CTL_W-1:0];
                n_read_data = {{(DATA_W-CTL_W){1'b0}}, n_ctrl_b};
            end
            default: begin
                n_read_data = '0;
            end
        endcase
    end

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_reg_a <= '0;
            r_dir_reg_a <= '0;
            r_dir_reg_b <= '0;
            r_port_b    <= PB_RESET;
            r_ctrl_a    <= '0;
            r_ctrl_b    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_out_reg_a <= n_out_reg_a;
                r_dir_reg_a <= n_dir_reg_a;
                r_dir_reg_b <= n_dir_reg_b;
                r_port_b    <= n_port_b;
                r_ctrl_a    <= n_ctrl_a;
                r_ctrl_b    <= n_ctrl_b;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, loaded with each transfer
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_read_data <= n_read_data;
            r_map_chg   <= n_map_chg;
            r_os_on     <= n_port_b[PB_OS_BIT];
            r_basic_on  <= !n_port_b[PB_BASIC_BIT];
            r_test_on   <= !n_port_b[PB_TEST_BIT];
        end
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.read_data       = r_read_data;
    assign o_rsp.os_rom_on       = r_os_on;
    assign o_rsp.basic_rom_on    = r_basic_on;
    assign o_rsp.selftest_rom_on = r_test_on;
    assign o_rsp.map_changed     = r_map_chg;

    // every transfer leaves a result waiting
    `PIA_ASSERT(a_result_follows, accept |=> o_rsp.valid, "transfer produced no result")

    // only a port B data write may report a map change
    `PIA_ASSERT(a_map_chg_src, (accept && !pb_data_wr) |=> (o_rsp.map_changed == '0), "map change without port B data write")

    // port B bits 6..2 are forced high by every data write
    `PIA_ASSERT(a_pb_forced_ones, (r_port_b & PB_FORCE_ONES) == PB_FORCE_ONES, "port B forced bits cleared")

endmodule

>>> tb/tb.sv
// Self-checking bench for the two-port PIA with ROM map enables.
// Depends on pia_pkg, pia_ifs.sv and pia_ports_with_rom_mapping.sv.
`timescale 1ns / 1ps

module tb;
    import pia_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 2;
    localparam int LONG_HOLD    = 40;       // receiver hold-off that backs up the block
    localparam int SETTLE       = 4;        // quiet cycles after the last result
    localparam int CYCLE_LIMIT  = 200000;   // far above the slowest legal run
    localparam int REPORT_MAX   = 10;

    // One bus access as offered on the request channel.
    typedef struct packed {
        logic              mode;
        logic [SEL_W-1:0]  reg_sel;
        logic [DATA_W-1:0] write_data;
        logic [DATA_W-1:0] joystick_in;
    } pia_access_t;

    // One result as seen on the response channel.
    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              os_rom_on;
        logic              basic_rom_on;
        logic              selftest_rom_on;
        logic [MAP_W-1:0]  map_changed;
    } pia_result_t;

    // Shadow copy of the PIA registers. Each accepted access is applied to
    // the shadow, and the result it produces is queued until the block
    // delivers its own result for that access.
    class pia_map_scoreboard;
        logic [DATA_W-1:0] out_a;
        logic [DATA_W-1:0] dir_a;
        logic [DATA_W-1:0] dir_b;
        logic [DATA_W-1:0] port_b;
        logic [CTL_W-1:0]  ctl_a;
        logic [CTL_W-1:0]  ctl_b;
        pia_result_t       pending_results[$];
        int                mismatches;
        int                checked;

        function new();
            out_a      = '0;
            dir_a      = '0;
            dir_b      = '0;
            port_b     = PB_RESET;
            ctl_a      = '0;
            ctl_b      = '0;
            mismatches = 0;
            checked    = 0;
        endfunction

        function void note_access(pia_access_t a);
            pia_result_t       r;
            logic              wr;
            logic [DATA_W-1:0] diff;
            r  = '0;
            wr = (a.mode == MODE_WRITE);
            case (a.reg_sel)
                SEL_PORT_A: begin
                    if (!ctl_a[CTL_DATA_BIT]) begin
                        if (wr) dir_a = a.write_data;
                        r.read_data = dir_a;
                    end else begin
                        if (wr) out_a = a.write_data;
                        // input pins pulled through where the direction is input
                        r.read_data = a.joystick_in & (out_a | ~dir_a);
                    end
                end
                SEL_PORT_B: begin
                    if (!ctl_b[CTL_DATA_BIT]) begin
                        if (wr) dir_b = a.write_data;
                        r.read_data = dir_b;
                    end else begin
                        if (wr) begin
                            diff = port_b ^ a.write_data;
                            r.map_changed[MAP_OS]    = diff[PB_OS_BIT];
                            r.map_changed[MAP_BASIC] = diff[PB_BASIC_BIT];
                            r.map_changed[MAP_TEST]  = diff[PB_TEST_BIT];
                            port_b = (a.write_data & PB_KEEP_MASK) | PB_FORCE_ONES;
                        end
                        // data read ignores the port B direction register
                        r.read_data = port_b;
                    end
                end
                SEL_CTRL_A: begin
                    if (wr) ctl_a = a.write_data[CTL_W-1:0];
                    r.read_data[CTL_W-1:0] = ctl_a;
                end
                default: begin
                    if (wr) ctl_b = a.write_data[CTL_W-1:0];
                    r.read_data[CTL_W-1:0] = ctl_b;
                end
            endcase
            r.os_rom_on       = port_b[PB_OS_BIT];
            r.basic_rom_on    = ~port_b[PB_BASIC_BIT];
            r.selftest_rom_on = ~port_b[PB_TEST_BIT];
            pending_results.push_back(r);
        endfunction

        function void check_result(pia_result_t got);
            pia_result_t want;
            logic        bad;
            checked++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected result rd=%02h map=%0b", got.read_data,
                             got.map_changed);
                return;
            end
            want = pending_results.pop_front();
            bad  = (got.read_data !== want.read_data) ||
                   (got.os_rom_on !== want.os_rom_on) ||
                   (got.basic_rom_on !== want.basic_rom_on) ||
                   (got.selftest_rom_on !== want.selftest_rom_on) ||
                   (got.map_changed !== want.map_changed);
            if (bad) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("mismatch: want rd=%02h os=%0b bas=%0b st=%0b chg=%03b",
                             want.read_data, want.os_rom_on, want.basic_rom_on,
                             want.selftest_rom_on, want.map_changed,
                             " / got rd=%02h os=%0b bas=%0b st=%0b chg=%03b",
                             got.read_data, got.os_rom_on, got.basic_rom_on,
                             got.selftest_rom_on, got.map_changed);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    pia_req_if req_bus ();
    pia_rsp_if rsp_bus ();

    pia_ports_with_rom_mapping DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    pia_map_scoreboard board;

    bit idle_enable;          // random gaps on both sides when set
    int long_holds_asked;     // bumped by the stimulus to request a long hold-off
    int long_holds_done;      // receiver's copy, so each request is served once
    int hold_left;            // receiver stall cycles still to go
    int cycle_count;
    int access_count[2][4];   // transfers by [mode][reg_sel]
    int map_switches;         // results reporting at least one region switched

    // Every input known from time zero; reset held low until the stimulus
    // releases it.
    initial begin
        i_clk               = 1'b0;
        i_rst_n             = 1'b0;
        req_bus.valid       = 1'b0;
        req_bus.mode        = MODE_READ;
        req_bus.reg_sel     = SEL_PORT_A;
        req_bus.write_data  = '0;
        req_bus.joystick_in = '0;
        rsp_bus.ready       = 1'b0;
        board               = new();
    end

    always #(CLK_HALF) i_clk = ~i_clk;

    // Response side. A long hold-off request keeps ready low through a LONG_HOLD
    // hold-off so the single result register fills and the request channel
    // stalls; otherwise short random stalls while idling is allowed.
    always @(posedge i_clk) begin
        if (long_holds_asked != long_holds_done) begin
            long_holds_done = long_holds_asked;
            hold_left       = LONG_HOLD;
        end
        if (hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
        end else if (idle_enable && $urandom_range(0, 4) == 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left      = $urandom_range(0, 2);
        end else begin
            rsp_bus.ready <= 1'b1;
        end
    end

    // Bus monitor. Both channels are sampled at the edge with the values
    // that stood before it. The result is checked ahead of noting a new
    // access, since any result leaving now belongs to an earlier transfer.
    always @(posedge i_clk) begin : bus_monitor
        pia_result_t got;
        pia_access_t acc;
        if (i_rst_n) begin
            if (rsp_bus.valid && rsp_bus.ready) begin
                got = '{read_data:       rsp_bus.read_data,
                        os_rom_on:       rsp_bus.os_rom_on,
                        basic_rom_on:    rsp_bus.basic_rom_on,
                        selftest_rom_on: rsp_bus.selftest_rom_on,
                        map_changed:     rsp_bus.map_changed};
                if (rsp_bus.map_changed != '0) map_switches++;
                board.check_result(got);
            end
            if (req_bus.valid && req_bus.ready) begin
                acc = '{mode:        req_bus.mode,
                        reg_sel:     req_bus.reg_sel,
                        write_data:  req_bus.write_data,
                        joystick_in: req_bus.joystick_in};
                access_count[acc.mode][acc.reg_sel]++;
                board.note_access(acc);
            end
        end
    end

    // Watchdog: a stuck handshake ends the run here.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    function automatic pia_access_t make_access(logic mode, logic [SEL_W-1:0] sel,
                                                logic [DATA_W-1:0] wd,
                                                logic [DATA_W-1:0] joy);
        pia_access_t a;
        a = '{mode: mode, reg_sel: sel, write_data: wd, joystick_in: joy};
        return a;
    endfunction

    // Offer one access and return at the edge where it is taken. Valid stays
    // high on return; the caller's next send or drain sets its next value.
    task automatic send_access(pia_access_t a);
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        req_bus.valid       <= 1'b1;
        req_bus.mode        <= a.mode;
        req_bus.reg_sel     <= a.reg_sel;
        req_bus.write_data  <= a.write_data;
        req_bus.joystick_in <= a.joystick_in;
        do @(posedge i_clk); while (!(req_bus.valid && req_bus.ready));
    endtask

    // Sender pause: nothing offered until every predicted result is back.
    // It first waits on the clock, so the monitor has noted the last transfer.
    task automatic drain_results();
        req_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Random accesses, port registers favored so data/direction routing and
    // port B map switching get most of the traffic; control writes carry a
    // full random byte so the data-select bit and the masked top bits flip.
    task automatic run_random(int count, bit allow_idle);
        pia_access_t      a;
        int               pick;
        logic [SEL_W-1:0] sel;
        for (int i = 0; i < count; i++) begin
            if (i % 50 == 0) idle_enable = allow_idle && ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 99);
            sel  = (pick < 35) ? SEL_PORT_A :
                   (pick < 70) ? SEL_PORT_B :
                   (pick < 85) ? SEL_CTRL_A : SEL_CTRL_B;
            a = make_access(($urandom_range(0, 99) < 60) ? MODE_WRITE : MODE_READ, sel,
                            DATA_W'($urandom_range(0, 255)),
                            DATA_W'($urandom_range(0, 255)));
            send_access(a);
        end
    endtask

    initial begin : stimulus
        pia_access_t directed[$];

        idle_enable      = 1'b1;
        long_holds_asked = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Port A: direction register at reset, full-byte direction write,
        // control write with the top bits masked, then data side with
        // all-output and all-input directions.
        directed.push_back(make_access(MODE_READ,  SEL_PORT_A, 8'h00, 8'h00));
        directed.push_back(make_access(MODE_WRITE, SEL_PORT_A, 8'hff, 8'h00));
        directed.push_back(make_access(MODE_READ,  SEL_PORT_A, 8'h00, 8'hff));
        directed.push_back(make_access(MODE_WRITE, SEL_CTRL_A, 8'hff, 8'h00));
        directed.push_back(make_access(MODE_READ,  SEL_CTRL_A, 8'h00, 8'h00));
        directed.push_back(make_access(MODE_WRITE, SEL_PORT_A, 8'h00, 8'hff));
        directed.push_back(make_access(MODE_READ,  SEL_PORT_A, 8'h00, 8'hff));
        directed.push_back(make_access(MODE_WRITE, SEL_CTRL_A, 8'h00, 8'h00));
        directed.push_back(make_access(MODE_WRITE, SEL_PORT_A, 8'h00, 8'h00));
        directed.push_back(make_access(MODE_WRITE, SEL_CTRL_A, 8'h04, 8'h00));
        directed.push_back(make_access(MODE_READ,  SEL_PORT_A, 8'h00, 8'h5a));
        directed.push_back(make_access(MODE_WRITE, SEL_PORT_A, 8'ha5, 8'hff));
        // read with a stray data byte must leave control A alone
        directed.push_back(make_access(MODE_READ,  SEL_CTRL_A, 8'hff, 8'h00));
        // Port B: direction side, then data side. Writes of 00 and 83 flip
        // all three regions; a repeat write switches nothing; a read with
        // a stray byte changes nothing; 01 flips BASIC and self-test only.
        directed.push_back(make_access(MODE_READ,  SEL_PORT_B, 8'h00, 8'h00));
        directed.push_back(make_access(MODE_WRITE, SEL_PORT_B, 8'hff, 8'h00));
        directed.push_back(make_access(MODE_WRITE, SEL_CTRL_B, 8'h04, 8'h00));
        directed.push_back(make_access(MODE_READ,  SEL_PORT_B, 8'h00, 8'h00));
        directed.push_back(make_access(MODE_WRITE, SEL_PORT_B, 8'h00, 8'h00));
        directed.push_back(make_access(MODE_WRITE, SEL_PORT_B, 8'h00, 8'h00));
        directed.push_back(make_access(MODE_READ,  SEL_PORT_B, 8'h83, 8'h00));
        directed.push_back(make_access(MODE_WRITE, SEL_PORT_B, 8'h83, 8'h00));
        directed.push_back(make_access(MODE_WRITE, SEL_PORT_B, 8'h01, 8'h00));
        // control B back to the direction side: port B data reads stop
        directed.push_back(make_access(MODE_WRITE, SEL_CTRL_B, 8'hc0, 8'h00));
        directed.push_back(make_access(MODE_READ,  SEL_PORT_B, 8'h00, 8'h00));
        directed.push_back(make_access(MODE_READ,  SEL_CTRL_B, 8'h00, 8'h00));
        foreach (directed[i]) send_access(directed[i]);
        drain_results();

        run_random(500, 1'b1);

        // Back-pressure: receiver holds off while accesses keep coming.
        long_holds_asked++;
        run_random(30, 1'b0);
        drain_results();

        run_random(500, 1'b1);
        drain_results();

        // Closing stretch at full rate on both sides.
        idle_enable = 1'b0;
        run_random(400, 1'b0);
        drain_results();
        repeat (SETTLE) @(posedge i_clk);

        $display("covered: port A r/w %0d/%0d, port B r/w %0d/%0d, control r/w %0d/%0d",
                 access_count[MODE_READ][SEL_PORT_A], access_count[MODE_WRITE][SEL_PORT_A],
                 access_count[MODE_READ][SEL_PORT_B], access_count[MODE_WRITE][SEL_PORT_B],
                 access_count[MODE_READ][SEL_CTRL_A] + access_count[MODE_READ][SEL_CTRL_B],
                 access_count[MODE_WRITE][SEL_CTRL_A] + access_count[MODE_WRITE][SEL_CTRL_B]);
        $display("%0d results checked, %0d with a ROM map switch, %0d mismatches",
                 board.checked, map_switches, board.mismatches);
        if (board.mismatches == 0 && board.pending_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
